### src/prewitt_vertical_edge_rgb_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertical Prewitt edge filter.
// Each macro expects signals named clk and arst_n in the scope of its use.
// ----------------------------------------------------------------------------
`ifndef PREWITT_VERTICAL_EDGE_RGB_DEFINES_SVH
`define PREWITT_VERTICAL_EDGE_RGB_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PVE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PVE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### src/pvedge_pkg.sv
// ----------------------------------------------------------------------------
// pvedge_pkg
// Types, register codes and kernel arithmetic for the vertical Prewitt
// edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pvedge_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Input item kinds.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// A stored pixel: red in [7:0], green in [15:8], blue in [23:16].
	localparam int PIX_W = 24;
	typedef logic [PIX_W-1:0] pixel_t;

	// Divide by three as a multiply by 683 / 2048, exact for values below 2048.
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;

	typedef struct packed {
		logic       opcode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
		logic       run_last;
	} out_item_t;

	function automatic logic [7:0] div3(input logic [9:0] d);
		logic [20:0] prod;
		prod = 21'(d) * 21'(DIV3_MUL);
		return prod[DIV3_SHIFT+7:DIV3_SHIFT];
	endfunction

	// One channel: |right column sum - left column sum| / 3.
	function automatic logic [7:0] prewitt_chan(
		input logic [7:0] lt, input logic [7:0] lm, input logic [7:0] lb,
		input logic [7:0] rt, input logic [7:0] rm, input logic [7:0] rb);
		logic [9:0] ls;
		logic [9:0] rs;
		logic [9:0] diff;
		ls   = 10'(lt) + 10'(lm) + 10'(lb);
		rs   = 10'(rt) + 10'(rm) + 10'(rb);
		diff = (rs >= ls) ? (rs - ls) : (ls - rs);
		return div3(diff);
	endfunction

	function automatic pixel_t prewitt(
		input pixel_t lt, input pixel_t lm, input pixel_t lb,
		input pixel_t rt, input pixel_t rm, input pixel_t rb);
		pixel_t res;
		for (int k = 0; k < 3; k++) begin
			res[8*k +: 8] = prewitt_chan(lt[8*k +: 8], lm[8*k +: 8], lb[8*k +: 8],
				rt[8*k +: 8], rm[8*k +: 8], rb[8*k +: 8]);
		end
		return res;
	endfunction

	function automatic out_item_t make_out(input pixel_t px, input logic fend,
		input logic last);
		out_item_t o;
		o.red_out   = px[7:0];
		o.green_out = px[15:8];
		o.blue_out  = px[23:16];
		o.frame_end = fend;
		o.run_last  = last;
		return o;
	endfunction

endpackage

`default_nettype wire

### src/prewitt_vertical_edge_rgb.sv
// ----------------------------------------------------------------------------
// prewitt_vertical_edge_rgb
// Streaming vertical Prewitt edge filter for RGB pixels in raster order,
// with two line stores, a two-column window and flush ticks for the last row.
// ----------------------------------------------------------------------------
// Channel | Signals                        | Handshake
// config  | cfg_we, cfg_index, cfg_data    | write when cfg_we is high
// input   | in_valid, in_stall, in_data    | taken when in_valid & !in_stall
// output  | out_valid, out_stall, out_data | taken when out_valid & !out_stall
//
// One input item is taken every cycle unless stalled; its results enter the output
// buffer (line store read at the accepting edge, then kernel). The last pixel
// of a row after the first gives two results; the two-entry buffer absorbs them.
// in_stall rises while stage 1 holds results that the output buffer cannot
// take in that cycle; it follows out_stall with no register in between.
// Reset loads 640 x 480; the line stores are not cleared and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module prewitt_vertical_edge_rgb
	import pvedge_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire in_item_t              in_data,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      out_item_t             out_data
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int RST_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
	localparam int RST_H = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

	typedef struct packed {
		logic pixel;
		logic emit;
		logic border;
		logic last_col;
		logic frame_end;
	} stage_ctl_t;

	// Frame geometry, kept as last column and last row indexes.
	logic [CW-1:0] last_col_q;
	logic [RW-1:0] last_row_q;
	logic [CW-1:0] new_last_col;
	logic [RW-1:0] new_last_row;
	logic [31:0]   w_req;
	logic [31:0]   h_req;

	// Raster position and flush state.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] flush_cnt_q;
	logic          flush_pend_q;

	// Stage 1 and window.
	logic          valid_s1;
	stage_ctl_t    ctl_s1;
	logic [CW-1:0] addr_s1;
	pixel_t        pin_s1;
	pixel_t        win_q [6];
	pixel_t        top_rd;
	pixel_t        mid_rd;

	// Output buffer.
	out_item_t     fifo_q [2];
	logic [1:0]    fifo_cnt_q;

	logic          in_acc;
	logic          is_pix;
	logic [CW-1:0] cur_col;
	logic [RW-1:0] cur_row;
	logic          is_last_col;
	logic          is_last_row;
	logic          flush_last;
	logic [CW-1:0] rd_addr;
	logic          load_s1;
	stage_ctl_t    ctl_in;
	logic          adv_s1;
	logic [1:0]    n_s1;
	logic          pop;
	logic [1:0]    rem_cnt;
	out_item_t     rem0;
	out_item_t     rem1;
	out_item_t     res0;
	out_item_t     res1;
	pixel_t        px_flt;
	pixel_t        px_sel;
	logic [1:0]    push_n;
	logic          ram_we;

	// Clamp of requested frame size into the supported range.
	always_comb begin
		w_req = 32'(cfg_data[11:0]);
		h_req = 32'(cfg_data[12:0]);
		if (w_req < 32'd3) begin
			new_last_col = CW'(2);
		end else if (w_req > 32'(MAX_WIDTH)) begin
			new_last_col = CW'(MAX_WIDTH - 1);
		end else begin
			new_last_col = CW'(w_req - 32'd1);
		end
		if (h_req < 32'd3) begin
			new_last_row = RW'(2);
		end else if (h_req > 32'(MAX_HEIGHT)) begin
			new_last_row = RW'(MAX_HEIGHT - 1);
		end else begin
			new_last_row = RW'(h_req - 32'd1);
		end
	end

	// Decode of the item at the input.
	always_comb begin
		in_acc      = in_valid && !in_stall;
		is_pix      = (in_data.opcode == OP_PIXEL);
		cur_col     = flush_pend_q ? '0 : col_q;
		cur_row     = flush_pend_q ? '0 : row_q;
		is_last_col = (cur_col == last_col_q);
		is_last_row = (cur_row == last_row_q);
		flush_last  = (flush_cnt_q == last_col_q);
		rd_addr     = is_pix ? cur_col : flush_cnt_q;
		load_s1     = in_acc && (is_pix || flush_pend_q);

		ctl_in.pixel     = is_pix;
		ctl_in.emit      = is_pix && (cur_row != '0) && (cur_col != '0);
		ctl_in.border    = (cur_row == RW'(1)) || (cur_col == CW'(1));
		ctl_in.last_col  = is_pix && is_last_col;
		ctl_in.frame_end = !is_pix && flush_last;
	end

	// Configuration registers and raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q   <= CW'(RST_W - 1);
			last_row_q   <= RW'(RST_H - 1);
			col_q        <= '0;
			row_q        <= '0;
			flush_cnt_q  <= '0;
			flush_pend_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  last_col_q <= new_last_col;
				REG_FRAME_HEIGHT: last_row_q <= new_last_row;
				default:          ;
			endcase
			col_q        <= '0;
			row_q        <= '0;
			flush_cnt_q  <= '0;
			flush_pend_q <= 1'b0;
		end else if (in_acc) begin
			if (is_pix) begin
				flush_pend_q <= 1'b0;
				if (flush_pend_q) begin
					flush_cnt_q <= '0;
				end
				if (is_last_col) begin
					col_q <= '0;
					if (is_last_row) begin
						row_q        <= '0;
						flush_cnt_q  <= '0;
						flush_pend_q <= 1'b1;
					end else begin
						row_q <= cur_row + RW'(1);
					end
				end else begin
					col_q <= cur_col + CW'(1);
					row_q <= cur_row;
				end
			end else if (flush_pend_q) begin
				if (flush_last) begin
					flush_pend_q <= 1'b0;
					flush_cnt_q  <= '0;
				end else begin
					flush_cnt_q <= flush_cnt_q + CW'(1);
				end
			end
		end
	end

	// Line stores: older row holds row r-2, newer row holds row r-1.
	assign ram_we = adv_s1 && ctl_s1.pixel;

	pvedge_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_older_row (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(addr_s1),
		.wr_data(mid_rd),
		.rd_en  (load_s1),
		.rd_addr(rd_addr),
		.rd_data(top_rd)
	);

	pvedge_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_newer_row (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(addr_s1),
		.wr_data(pin_s1),
		.rd_en  (load_s1),
		.rd_addr(rd_addr),
		.rd_data(mid_rd)
	);

	// Stage 1 occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			ctl_s1  <= ctl_in;
			addr_s1 <= rd_addr;
			pin_s1  <= {in_data.blue_in, in_data.green_in, in_data.red_in};
		end
	end

	// Window: entries 0..2 are the previous column, 3..5 the one before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (ram_we) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= top_rd;
			win_q[1] <= mid_rd;
			win_q[2] <= pin_s1;
		end
	end

	// Kernel and result selection for the item in stage 1.
	always_comb begin
		px_flt = prewitt(win_q[3], win_q[4], win_q[5], top_rd, mid_rd, pin_s1);
		if (ctl_s1.pixel) begin
			px_sel = ctl_s1.border ? win_q[1] : px_flt;
			n_s1   = ctl_s1.emit ? (ctl_s1.last_col ? 2'd2 : 2'd1) : 2'd0;
		end else begin
			px_sel = mid_rd;
			n_s1   = 2'd1;
		end
		res0 = make_out(px_sel, ctl_s1.frame_end, !ctl_s1.last_col);
		res1 = make_out(mid_rd, 1'b0, 1'b1);
	end

	// Output buffer bookkeeping: pop from the head, then append new results.
	always_comb begin
		out_valid = (fifo_cnt_q != 2'd0);
		out_data  = fifo_q[0];
		pop       = out_valid && !out_stall;
		if (pop) begin
			rem0    = fifo_q[1];
			rem1    = fifo_q[1];
			rem_cnt = fifo_cnt_q - 2'd1;
		end else begin
			rem0    = fifo_q[0];
			rem1    = fifo_q[1];
			rem_cnt = fifo_cnt_q;
		end
		adv_s1   = valid_s1 && ((3'(rem_cnt) + 3'(n_s1)) <= 3'd2);
		push_n   = adv_s1 ? n_s1 : 2'd0;
		in_stall = valid_s1 && !adv_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_cnt_q <= 2'd0;
		end else begin
			fifo_cnt_q <= rem_cnt + push_n;
		end
	end

	always_ff @(posedge clk) begin
		if (rem_cnt == 2'd0) begin
			fifo_q[0] <= res0;
			fifo_q[1] <= res1;
		end else if (rem_cnt == 2'd1) begin
			fifo_q[0] <= rem0;
			fifo_q[1] <= res0;
		end else begin
			fifo_q[0] <= rem0;
			fifo_q[1] <= rem1;
		end
	end

endmodule

`default_nettype wire

### src/pvedge_ram.sv
// ----------------------------------------------------------------------------
// pvedge_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module pvedge_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### src/pvedge_checker.sv
// ----------------------------------------------------------------------------
// pvedge_checker
// Port-level checks for the vertical Prewitt edge filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prewitt_vertical_edge_rgb_defines.svh"

module pvedge_checker
	import pvedge_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	// A stalled request holds still until it is taken.
	`PVE_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "input changed while stalled")

	// A result that waits must hold still.
	`PVE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output changed while stalled")

	// With nothing buffered at the output, the input never stalls.
	`PVE_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall, "input stalled with empty output")

	// The frame end is always the only result of its flush tick.
	`PVE_ASSERT_NOW(a_fend_last, out_valid && out_data.frame_end, out_data.run_last, "frame end without run end")

	// The second result of a row end follows right after the first.
	`PVE_ASSERT_NEXT(a_pair_follows, out_valid && !out_stall && !out_data.run_last, out_valid && !out_data.frame_end, "second row-end result missing")

endmodule

bind prewitt_vertical_edge_rgb pvedge_checker u_pvedge_checker (.*);

`default_nettype wire

### tb/tb_prewitt_vertical_edge_rgb.sv
// ----------------------------------------------------------------------------
// tb_prewitt_vertical_edge_rgb
// Self-checking bench for the streaming vertical Prewitt filter. A local
// predictor keeps its own line stores, window and counters. It works out the
// output pixels of every accepted request, and each result is checked field
// by field in order. Directed frames cover the kernel extremes and the flush
// rules. Random frames run over many small geometries with noise ticks and
// broken flush sequences. The run ends with a long output hold-off and with
// register values at the top of the width and height ranges.
// ----------------------------------------------------------------------------
module tb_prewitt_vertical_edge_rgb
	import pvedge_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MODEL_MAX_W  = 2048;
	localparam int MODEL_MAX_H  = 4096;
	localparam int RANDOM_ITEMS = 250;
	localparam int RESET_ITEMS  = 20;
	localparam int EDGE_ITEMS   = 30;
	localparam int DRAIN_CYCLES = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;

	// Idling controls shared by the stimulus and the output stall process.
	bit sender_idle;
	bit receiver_idle;
	int hold_off_cycles;

	// Predictor state: line stores, the two-column window and frame counters.
	pixel_t      older_rows [MODEL_MAX_W];
	pixel_t      newer_rows [MODEL_MAX_W];
	pixel_t      window_px [6] = '{default: '0};
	int unsigned row_idx     = 0;
	int unsigned col_idx     = 0;
	int unsigned flush_idx   = 0;
	bit          flush_armed = 1'b0;
	logic [11:0] width_reg   = 12'd640;
	logic [12:0] height_reg  = 13'd480;

	out_item_t expected_pixels [$];
	int        fail_count = 0;

	prewitt_vertical_edge_rgb #(
		.MAX_WIDTH(MODEL_MAX_W),
		.MAX_HEIGHT(MODEL_MAX_H)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard limit on the whole run.
	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	function automatic int unsigned active_width();
		if (width_reg < 3) begin
			return 3;
		end
		if (width_reg > MODEL_MAX_W) begin
			return MODEL_MAX_W;
		end
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		if (height_reg < 3) begin
			return 3;
		end
		if (height_reg > MODEL_MAX_H) begin
			return MODEL_MAX_H;
		end
		return height_reg;
	endfunction

	function automatic void restart_frame();
		row_idx     = 0;
		col_idx     = 0;
		flush_idx   = 0;
		flush_armed = 1'b0;
	endfunction

	// Per channel: |right column sum - left column sum| / 3, truncated.
	function automatic pixel_t vertical_gradient(input pixel_t lt, input pixel_t lm,
		input pixel_t lb, input pixel_t rt, input pixel_t rm, input pixel_t rb);
		pixel_t g;
		int     left_sum;
		int     right_sum;
		int     diff;
		int     k;
		for (k = 0; k < 3; k++) begin
			left_sum  = int'(lt[8*k +: 8]) + int'(lm[8*k +: 8]) + int'(lb[8*k +: 8]);
			right_sum = int'(rt[8*k +: 8]) + int'(rm[8*k +: 8]) + int'(rb[8*k +: 8]);
			diff      = (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
			g[8*k +: 8] = 8'(diff / 3);
		end
		return g;
	endfunction

	function automatic out_item_t to_result(input pixel_t px, input logic fend);
		out_item_t o;
		o.red_out   = px[7:0];
		o.green_out = px[15:8];
		o.blue_out  = px[23:16];
		o.frame_end = fend;
		o.run_last  = 1'b0;
		return o;
	endfunction

	// Works out the output pixels caused by one accepted request.
	function automatic void predict_request(input in_item_t req);
		out_item_t   res [$];
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		pixel_t      pin;
		pixel_t      top;
		pixel_t      mid;
		pixel_t      px;
		w = active_width();
		h = active_height();
		if (req.opcode == OP_FLUSH) begin
			// A flush tick only counts while the last row is still owed.
			if (!flush_armed) begin
				return;
			end
			if (flush_idx >= w) begin
				flush_idx = w - 1;
			end
			res.push_back(to_result(newer_rows[flush_idx], flush_idx == w - 1));
			if (flush_idx == w - 1) begin
				flush_armed = 1'b0;
				flush_idx   = 0;
			end else begin
				flush_idx++;
			end
		end else begin
			// A pixel during a flush drops the rest and opens a new frame.
			if (flush_armed) begin
				restart_frame();
			end
			if (col_idx >= w) begin
				col_idx = 0;
			end
			if (row_idx >= h) begin
				row_idx = 0;
			end
			c   = col_idx;
			r   = row_idx;
			pin = {req.blue_in, req.green_in, req.red_in};
			top = older_rows[c];
			mid = newer_rows[c];
			if (r >= 1 && c >= 1) begin
				if (r == 1 || c == 1) begin
					px = window_px[1];
				end else begin
					px = vertical_gradient(window_px[3], window_px[4], window_px[5],
						top, mid, pin);
				end
				res.push_back(to_result(px, 1'b0));
				// The right border pixel of the row above leaves with the last column.
				if (c == w - 1) begin
					res.push_back(to_result(mid, 1'b0));
				end
			end
			window_px[3] = window_px[0];
			window_px[4] = window_px[1];
			window_px[5] = window_px[2];
			window_px[0] = top;
			window_px[1] = mid;
			window_px[2] = pin;
			older_rows[c] = mid;
			newer_rows[c] = pin;
			if (c == w - 1) begin
				col_idx = 0;
				if (r == h - 1) begin
					row_idx     = 0;
					flush_idx   = 0;
					flush_armed = 1'b1;
				end else begin
					row_idx = r + 1;
				end
			end else begin
				col_idx = c + 1;
			end
		end
		if (res.size() > 0) begin
			res[res.size() - 1].run_last = 1'b1;
		end
		foreach (res[i]) begin
			expected_pixels.push_back(res[i]);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch($sformatf("result %h arrived with nothing expected", got));
			return;
		end
		want = expected_pixels.pop_front();
		if (got.red_out !== want.red_out) begin
			report_mismatch($sformatf("red_out got %h expected %h", got.red_out,
				want.red_out));
		end
		if (got.green_out !== want.green_out) begin
			report_mismatch($sformatf("green_out got %h expected %h", got.green_out,
				want.green_out));
		end
		if (got.blue_out !== want.blue_out) begin
			report_mismatch($sformatf("blue_out got %h expected %h", got.blue_out,
				want.blue_out));
		end
		if (got.frame_end !== want.frame_end) begin
			report_mismatch($sformatf("frame_end got %b expected %b", got.frame_end,
				want.frame_end));
		end
		if (got.run_last !== want.run_last) begin
			report_mismatch($sformatf("run_last got %b expected %b", got.run_last,
				want.run_last));
		end
	endtask

	// Both handshakes are sampled at the rising edge, before any update of it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_request(in_data);
			end
			if (out_valid && !out_stall) begin
				check_result(out_data);
			end
		end
	end

	// Output side: random stall bursts, or one long hold-off when asked.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
				out_stall <= 1'b0;
			end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic in_item_t pixel_request(input pixel_t px);
		in_item_t req;
		req.opcode   = OP_PIXEL;
		req.red_in   = px[7:0];
		req.green_in = px[15:8];
		req.blue_in  = px[23:16];
		return req;
	endfunction

	function automatic in_item_t random_pixel();
		return pixel_request(pixel_t'($urandom()));
	endfunction

	// Flush ticks carry random channel bits; the block must ignore them.
	function automatic in_item_t flush_request();
		in_item_t req;
		req        = pixel_request(pixel_t'($urandom()));
		req.opcode = OP_FLUSH;
		return req;
	endfunction

	// Offers one request and returns at the edge where it is taken. Valid
	// stays high for the next request unless a sender gap comes first.
	task automatic send_request(input in_item_t req);
		if (sender_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	// Waits until every expected result has come and the pipeline is empty.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write; any write restarts the frame in the block.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = value[11:0];
		end else if (idx == REG_FRAME_HEIGHT) begin
			height_reg = value;
		end
		restart_frame();
		@(posedge clk);
	endtask

	// Three rows that share one column pattern.
	task automatic send_bar_frame(input pixel_t left, input pixel_t center,
		input pixel_t right);
		repeat (3) begin
			send_request(pixel_request(left));
			send_request(pixel_request(center));
			send_request(pixel_request(right));
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset geometry of 640 x 480: part of the first row gives no results.
	task automatic test_reset_geometry();
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		repeat (RESET_ITEMS) send_request(random_pixel());
		drain_block();
	endtask

	// Smallest frame, given as register values below the minimum, with the
	// kernel at full scale in both directions and every flush rule.
	task automatic test_directed_corners();
		write_register(REG_FRAME_WIDTH, '0);
		write_register(REG_FRAME_HEIGHT, 13'd2);
		// Flush tick with no frame behind it: ignored.
		send_request(flush_request());
		send_bar_frame(24'hFFFFFF, 24'h123456, 24'h000000);
		// Full last row, then one surplus tick that must be ignored.
		repeat (4) send_request(flush_request());
		send_bar_frame(24'h00FF80, 24'h5A5A5A, 24'hFF007F);
		// A pixel cuts the flush short and starts a new frame.
		send_request(flush_request());
		send_request(pixel_request(24'hA5C3E1));
		drain_block();
	endtask

	// Random small geometries with mostly complete frames and some noise.
	task automatic test_random_frames();
		int unsigned sent;
		int unsigned w_raw;
		int unsigned h_raw;
		int unsigned w;
		int unsigned h;
		int unsigned pixels;
		int unsigned flushes;
		int unsigned choice;
		int unsigned i;
		bit          whole_frame;
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			choice = $urandom_range(0, 9);
			w_raw  = (choice == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
			choice = $urandom_range(0, 11);
			if (choice == 0) begin
				h_raw = $urandom_range(0, 2);
			end else if (choice == 1) begin
				h_raw = 8191;
			end else begin
				h_raw = $urandom_range(3, 6);
			end
			drain_block();
			write_register(REG_FRAME_WIDTH, CFG_DATA_W'(w_raw));
			write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(h_raw));
			w = active_width();
			h = active_height();
			repeat ($urandom_range(1, 3)) begin
				whole_frame = (h_raw != 8191) && ($urandom_range(0, 9) != 0);
				pixels      = whole_frame ? w * h : $urandom_range(1, 3 * w);
				for (i = 0; i < pixels; i++) begin
					// Stray flush ticks inside a frame are ignored.
					if ($urandom_range(0, 24) == 0) begin
						send_request(flush_request());
					end
					send_request(random_pixel());
				end
				sent += pixels;
				// Mostly a complete last row; sometimes cut short or overlong.
				choice = $urandom_range(0, 19);
				if (choice < 14) begin
					flushes = w;
				end else if (choice < 17) begin
					flushes = $urandom_range(0, w - 1);
				end else begin
					flushes = w + $urandom_range(1, 3);
				end
				repeat (flushes) send_request(flush_request());
				if (whole_frame) begin
					sent += (flushes < w) ? flushes : w;
				end
			end
		end
		drain_block();
	endtask

	// The receiver holds off while requests keep coming, so the block fills.
	task automatic test_output_backpressure();
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		write_register(REG_FRAME_WIDTH, 13'd7);
		write_register(REG_FRAME_HEIGHT, 13'd4);
		hold_off_cycles = 60;
		repeat (2) begin
			repeat (28) send_request(random_pixel());
			repeat (7) send_request(flush_request());
		end
		drain_block();
	endtask

	// Widest rows: the exact maximum and a value beyond it that clamps; the
	// first row is still open when the requests stop, so nothing comes out.
	task automatic test_widest_rows();
		logic [CFG_DATA_W-1:0] widths [2];
		widths = '{13'd2048, 13'd4095};
		foreach (widths[i]) begin
			write_register(REG_FRAME_WIDTH, widths[i]);
			write_register(REG_FRAME_HEIGHT, 13'd5);
			repeat (EDGE_ITEMS) send_request(random_pixel());
			drain_block();
		end
	endtask

	// Tallest frame, written as the largest field value: after ten rows the
	// frame is still open, so the flush ticks that follow are ignored.
	task automatic test_tallest_frame();
		write_register(REG_FRAME_WIDTH, 13'd3);
		write_register(REG_FRAME_HEIGHT, 13'h1FFF);
		repeat (EDGE_ITEMS) send_request(random_pixel());
		repeat (3) send_request(flush_request());
		drain_block();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_FRAME_WIDTH;
		cfg_data        = '0;
		in_valid        = 1'b0;
		in_data         = '0;
		sender_idle     = 1'b0;
		receiver_idle   = 1'b0;
		hold_off_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_directed_corners();
		test_random_frames();
		// No idling from here on.
		test_output_backpressure();
		test_widest_rows();
		test_tallest_frame();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_pixels.size()));
		end
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### prewitt_vertical_edge_rgb.f
+incdir+src
src/pvedge_pkg.sv
src/pvedge_ram.sv
src/prewitt_vertical_edge_rgb.sv
src/pvedge_checker.sv
tb/tb_prewitt_vertical_edge_rgb.sv
